[hdl/msopt_pkg.sv]
// package: types and codes for the multi-slot timer
package msopt_pkg;
  localparam int unsigned ModeW = 3;
  localparam int unsigned KindW = 3;
  localparam int unsigned StepW = 10;
  localparam logic [StepW-1:0] StepReset = 10'd12;
  localparam int unsigned MaxResults = 16; // expiries reported per tick at most

  localparam logic [ModeW-1:0] ModeTick   = 3'd0;
  localparam logic [ModeW-1:0] ModeArm    = 3'd1;
  localparam logic [ModeW-1:0] ModeWait   = 3'd2;
  localparam logic [ModeW-1:0] ModeQuery  = 3'd3;
  localparam logic [ModeW-1:0] ModeAbort  = 3'd4;

  localparam logic [KindW-1:0] KindExpiry   = 3'd0;
  localparam logic [KindW-1:0] KindArmed    = 3'd1;
  localparam logic [KindW-1:0] KindWaitCnt  = 3'd2;
  localparam logic [KindW-1:0] KindBlock    = 3'd3;
  localparam logic [KindW-1:0] KindPeriodic = 3'd4;
  localparam logic [KindW-1:0] KindFired    = 3'd5;
  localparam logic [KindW-1:0] KindPending  = 3'd6;
  localparam logic [KindW-1:0] KindAborted  = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  result_slot;
    logic [2:0]  kind;
    logic [31:0] event_count;
    logic        last;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

[hdl/msopt_div.sv]
// serial restoring divider, one quotient bit per cycle
module msopt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msopt_pkg::div_req_t req_i,
  output msopt_pkg::div_rsp_t rsp_o
);
  import msopt_pkg::*;

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[31:0], quot_q[63]};
    diff = {1'b0, shifted} - {2'b00, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d  = diff[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[31:0];
endmodule

[hdl/multi_slot_oneshot_periodic_timer.sv]
// top level: millisecond clock, slot table and request sequencer
// arm/query/abort/one-shot wait: idle, pick, then the result is held for output
// periodic wait poll: pick, the 64-step shared divide, then the result
// tick: a scan of every slot, then per expiry a pick and the rescan that decides
//   last, with a periodic divide before the rescan, plus output wait
// one request at a time, ready only when idle; reset clears clock, slots, step 12
module multi_slot_oneshot_periodic_timer #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msopt_pkg::req_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msopt_pkg::rsp_t     out_data_o,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_wdata_i
);
  import msopt_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);
  localparam logic [CntW-1:0] NumT = CntW'(NUM_TIMERS);
  localparam logic [CntW-1:0] MaxRes =
    CntW'(MaxResults < NUM_TIMERS ? MaxResults : NUM_TIMERS);
  localparam logic [63:0] U64Max = '1;

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1; // walk slots looking for earliest due
  localparam logic [2:0] StPick = 3'd2; // act on chosen slot
  localparam logic [2:0] StDiv  = 3'd3; // wait for catch-up divide
  localparam logic [2:0] StOut  = 3'd4; // hold result until taken

  logic [2:0] st_q, st_d;
  logic [StepW-1:0] step_q;
  logic [63:0] now_q, now_d;
  logic [63:0] dl_q [NUM_TIMERS];
  logic [31:0] per_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed_q, armed_d, done_q, done_d;

  req_t req_q, req_d;
  rsp_t rsp_q, rsp_d;
  logic [CntW-1:0] scan_q, scan_d;   // scan position
  logic [CntW-1:0] nres_q, nres_d;   // expiries given this tick
  logic            found_q, found_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [63:0]     bestdl_q, bestdl_d;
  logic            held_q, held_d;   // expiry waits in rsp_q while rescan decides last

  // slot write port
  logic            dl_we, per_we;
  logic [IdxW-1:0] wr_idx;
  logic [63:0]     dl_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  msopt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [IdxW-1:0] sidx, scan_idx;
  logic [63:0]     s_dl, c_dl;
  logic [31:0]     s_per;
  logic [63:0]     nx_dl;
  logic [64:0]     nx_sum;
  logic [31:0]     nx_cnt;

  assign sidx     = IdxW'(req_q.slot);
  assign scan_idx = scan_q[IdxW-1:0];
  assign s_dl     = dl_q[best_q];
  assign s_per    = per_q[best_q];
  assign c_dl     = dl_q[scan_idx];

  // catch-up result: deadline = now - rem + period (saturating)
  assign nx_sum = {1'b0, now_q - {32'd0, div_rsp.rem}} + {33'd0, s_per};
  assign nx_dl  = nx_sum[64] ? U64Max : nx_sum[63:0];
  assign nx_cnt = (div_rsp.quot >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                  : div_rsp.quot[31:0] + 32'd1;

  always_comb begin
    logic [64:0] sum;
    logic        nxt;
    st_d = st_q; now_d = now_q; armed_d = armed_q; done_d = done_q;
    req_d = req_q; rsp_d = rsp_q; scan_d = scan_q; nres_d = nres_q;
    found_d = found_q; best_d = best_q; bestdl_d = bestdl_q; held_d = held_q;
    dl_we = 1'b0; per_we = 1'b0; wr_idx = best_q; dl_wdata = nx_dl;
    div_req.start = 1'b0;
    div_req.dividend = now_q - s_dl;
    div_req.divisor = s_per;
    sum = '0;
    // another expiry is due and the per-tick cap is not reached
    nxt = found_q && (nres_q != MaxRes);
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          best_d = IdxW'(in_data_i.slot);
          if (in_data_i.mode == ModeTick) begin
            sum = {1'b0, now_q} + {55'd0, step_q};
            now_d = sum[64] ? U64Max : sum[63:0];
            done_d = '0; nres_d = '0; scan_d = '0; found_d = 1'b0;
            held_d = 1'b0;
            st_d = StScan;
          end else if (in_data_i.mode <= ModeAbort &&
                       32'(in_data_i.slot) < NUM_TIMERS) begin
            st_d = StPick;
          end
          // unused modes and slots out of range are dropped here
        end
      end
      StScan: begin
        if (scan_q == NumT) begin
          if (held_q) begin
            // held expiry is last unless another one follows
            rsp_d.last = !nxt;
            held_d = 1'b0;
            st_d = StOut;
          end else if (nxt) begin
            st_d = StPick;
          end else begin
            st_d = StIdle;
          end
        end else begin
          if (armed_q[scan_idx] && !done_q[scan_idx] && c_dl <= now_q &&
              (!found_q || c_dl < bestdl_q)) begin
            found_d = 1'b1; best_d = scan_idx; bestdl_d = c_dl;
          end
          scan_d = scan_q + CntW'(1);
        end
      end
      StPick: begin
        rsp_d.result_slot = 4'(best_q);
        rsp_d.event_count = '0;
        rsp_d.last = 1'b1;
        st_d = StOut;
        if (req_q.mode == ModeTick) begin
          done_d[best_q] = 1'b1;
          nres_d = nres_q + CntW'(1);
          rsp_d.kind = KindExpiry;
          if (s_per != 0) begin
            div_req.start = 1'b1;
            st_d = StDiv;
          end else begin
            armed_d[best_q] = 1'b0;
            rsp_d.event_count = 32'd1;
            // rescan to find out whether this expiry is the last one
            scan_d = '0; found_d = 1'b0; held_d = 1'b1;
            st_d = StScan;
          end
        end else begin
          unique case (req_q.mode)
            ModeArm: begin
              sum = {1'b0, now_q} + {33'd0, req_q.delay_ms};
              dl_we = 1'b1; per_we = 1'b1; wr_idx = sidx;
              dl_wdata = sum[64] ? U64Max : sum[63:0];
              armed_d[sidx] = 1'b1;
              rsp_d.kind = KindArmed;
            end
            ModeWait: begin
              rsp_d.kind = KindWaitCnt;
              if (s_dl > now_q) begin
                armed_d[sidx] = 1'b1;
                rsp_d.kind = KindBlock;
              end else if (s_per != 0) begin
                div_req.start = 1'b1;
                st_d = StDiv;
              end else begin
                rsp_d.event_count = {31'd0, armed_q[sidx]};
                armed_d[sidx] = 1'b0;
              end
            end
            ModeQuery: begin
              rsp_d.kind = (s_per != 0) ? KindPeriodic :
                           (armed_q[sidx] ? KindPending : KindFired);
            end
            default: begin
              armed_d[sidx] = 1'b0;
              rsp_d.kind = KindAborted;
            end
          endcase
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          dl_we = 1'b1;
          armed_d[best_q] = 1'b1;
          rsp_d.event_count = nx_cnt;
          if (req_q.mode == ModeTick) begin
            scan_d = '0; found_d = 1'b0; held_d = 1'b1;
            st_d = StScan;
          end else begin
            st_d = StOut;
          end
        end
      end
      StOut: begin
        if (out_ready_i) begin
          // a tick result that is not last already has its next slot in best_q
          st_d = (req_q.mode == ModeTick && !rsp_q.last) ? StPick : StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = (st_q == StOut);
  assign out_data_o  = rsp_q;
  assign in_ready_o  = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; step_q <= StepReset; now_q <= '0;
      armed_q <= '0; done_q <= '0; scan_q <= '0; nres_q <= '0;
      found_q <= 1'b0; held_q <= 1'b0;
      rsp_q <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        dl_q[i] <= '0; per_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;
      st_q <= st_d; now_q <= now_d; armed_q <= armed_d; done_q <= done_d;
      scan_q <= scan_d; nres_q <= nres_d; found_q <= found_d;
      held_q <= held_d; rsp_q <= rsp_d;
      if (dl_we) dl_q[wr_idx] <= dl_wdata;
      if (per_we) per_q[wr_idx] <= req_q.period_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    best_q <= best_d;
    bestdl_q <= bestdl_d;
  end
endmodule

[sim/tb_multi_slot_oneshot_periodic_timer.sv]
// testbench for the multi-slot timer: directed and random requests checked against a predictor
module tb_multi_slot_oneshot_periodic_timer;
  timeunit 1ns;
  timeprecision 1ps;
  import msopt_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned MaxExpiries = 16;
  localparam logic [63:0] ClockMax = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  localparam int unsigned DrainCycles = 3000;

  // scoreboard: holds the results still owed by the block, in order
  class timer_scoreboard;
    rsp_t owed_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function void note_request(rsp_t exp_q[$]);
      foreach (exp_q[i]) owed_q.push_back(exp_q[i]);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      results_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slot %0d kind %0d count %0d last %0b",
                   got.result_slot, got.kind, got.event_count, got.last);
        return;
      end
      exp = owed_q.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp slot %0d kind %0d count %0d last %0b,",
                    " got slot %0d kind %0d count %0d last %0b"},
                   exp.result_slot, exp.kind, exp.event_count, exp.last,
                   got.result_slot, got.kind, got.event_count, got.last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic [9:0] cfg_wdata_i;

  multi_slot_oneshot_periodic_timer #(.NUM_TIMERS(NumSlots)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  // predictor state: mirrors the slot table and the millisecond clock
  logic [9:0]  step_ms;
  logic [63:0] clock_ms;
  logic [63:0] slot_deadline [NumSlots];
  logic [31:0] slot_period [NumSlots];
  logic        slot_armed [NumSlots];

  timer_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned requests_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ClockMax : s[63:0];
  endfunction

  // periodic catch-up: count of elapsed periods, deadline moved past the clock
  function automatic logic [31:0] catch_up(int unsigned s);
    logic [63:0] late;
    logic [63:0] quo;
    logic [63:0] per;
    per = {32'd0, slot_period[s]};
    late = clock_ms - slot_deadline[s];
    quo = late / per;
    slot_deadline[s] = sat_sum(clock_ms - (late % per), per);
    slot_armed[s] = 1'b1;
    return (quo >= {32'd0, CountMax}) ? CountMax : quo[31:0] + 32'd1;
  endfunction

  function automatic rsp_t make_rsp(int unsigned s, logic [2:0] k, logic [31:0] c);
    rsp_t r;
    r.result_slot = s[3:0];
    r.kind = k;
    r.event_count = c;
    r.last = 1'b0;
    return r;
  endfunction

  // computes the results one request causes and updates the mirrored state
  function automatic void predict_request(req_t rq, ref rsp_t res_q[$]);
    bit done [NumSlots];
    int best;
    int unsigned s;
    res_q.delete();
    s = 32'(rq.slot);
    if (rq.mode == ModeTick) begin
      foreach (done[i]) done[i] = 0;
      clock_ms = sat_sum(clock_ms, {54'd0, step_ms});
      while (res_q.size() < MaxExpiries) begin
        best = -1;
        for (int i = 0; i < NumSlots; i++) begin
          if (!slot_armed[i] || done[i] || slot_deadline[i] > clock_ms) continue;
          if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
        end
        if (best < 0) break;
        done[best] = 1;
        if (slot_period[best] != 0) begin
          res_q.push_back(make_rsp(best, KindExpiry, catch_up(best)));
        end else begin
          slot_armed[best] = 1'b0;
          res_q.push_back(make_rsp(best, KindExpiry, 32'd1));
        end
      end
    end else if (rq.mode == ModeArm) begin
      slot_deadline[s] = sat_sum(clock_ms, {32'd0, rq.delay_ms});
      slot_period[s] = rq.period_ms;
      slot_armed[s] = 1'b1;
      res_q.push_back(make_rsp(s, KindArmed, 0));
    end else if (rq.mode == ModeWait) begin
      if (slot_deadline[s] > clock_ms) begin
        slot_armed[s] = 1'b1;
        res_q.push_back(make_rsp(s, KindBlock, 0));
      end else if (slot_period[s] != 0) begin
        res_q.push_back(make_rsp(s, KindWaitCnt, catch_up(s)));
      end else begin
        res_q.push_back(make_rsp(s, KindWaitCnt, {31'd0, slot_armed[s]}));
        slot_armed[s] = 1'b0;
      end
    end else if (rq.mode == ModeQuery) begin
      if (slot_period[s] != 0) res_q.push_back(make_rsp(s, KindPeriodic, 0));
      else res_q.push_back(make_rsp(s, slot_armed[s] ? KindPending : KindFired, 0));
    end else if (rq.mode == ModeAbort) begin
      slot_armed[s] = 1'b0;
      res_q.push_back(make_rsp(s, KindAborted, 0));
    end
    // modes above abort are ignored by the block
    if (res_q.size() > 0) res_q[res_q.size()-1].last = 1'b1;
  endfunction

  // one request: random idle, then hold valid until accepted
  // valid stays up into the next request unless the sender idles
  task automatic send_request(req_t rq);
    rsp_t res_q[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(rq, res_q);
    sb.note_request(res_q);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [2:0] m, logic [3:0] s, logic [31:0] d, logic [31:0] p);
    req_t rq;
    rq.mode = m;
    rq.slot = s;
    rq.delay_ms = d;
    rq.period_ms = p;
    send_request(rq);
  endtask

  // waits for all owed results, then lets any trailing work settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_step(logic [9:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    step_ms = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random request mix, mostly arm/tick with some wait/query/abort and noise
  task automatic random_requests(int unsigned n);
    int unsigned r;
    logic [31:0] d;
    logic [31:0] p;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: d = $urandom_range(60);
        1: d = $urandom_range(400);
        2: d = $urandom;
        default: d = 32'hFFFF_FFFF - $urandom_range(3);
      endcase
      case ($urandom_range(4))
        0, 1: p = 0;
        2: p = $urandom_range(1, 30);
        3: p = $urandom_range(1, 500);
        default: p = $urandom;
      endcase
      if (r < 35) send_fields(ModeTick, 4'($urandom), $urandom, $urandom);
      else if (r < 65) send_fields(ModeArm, 4'($urandom), d, p);
      else if (r < 78) send_fields(ModeWait, 4'($urandom), $urandom, $urandom);
      else if (r < 88) send_fields(ModeQuery, 4'($urandom), $urandom, $urandom);
      else if (r < 95) send_fields(ModeAbort, 4'($urandom), $urandom, $urandom);
      else send_fields(3'($urandom_range(5, 7)), 4'($urandom), $urandom, $urandom);
    end
  endtask

  // receiver: stalls at random, checks every accepted result
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    requests_sent = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    step_ms = StepReset;
    clock_ms = 0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_deadline[i] = 0;
      slot_period[i] = 0;
      slot_armed[i] = 1'b0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every mode, field extremes, ties, catch-up, ignored requests
    send_fields(ModeQuery, 4'd0, 32'd0, 32'd0);          // fresh slot reads fired
    send_fields(ModeWait, 4'd15, 32'd0, 32'd0);          // unarmed one-shot poll
    send_fields(ModeArm, 4'd3, 32'd5, 32'd0);
    send_fields(ModeArm, 4'd1, 32'd5, 32'd0);            // tie with slot 3
    send_fields(ModeArm, 4'd0, 32'd1, 32'd2);            // periodic, catches up
    send_fields(ModeArm, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(ModeQuery, 4'd1, 32'd0, 32'd0);
    send_fields(ModeQuery, 4'd0, 32'd0, 32'd0);
    send_fields(ModeTick, 4'd0, 32'd0, 32'd0);
    send_fields(ModeWait, 4'd15, 32'd0, 32'd0);          // would block
    send_fields(ModeAbort, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(3'd5, 4'd2, 32'd0, 32'd0);               // unused modes
    send_fields(3'd7, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(ModeArm, 4'd2, 32'd0, 32'd0);
    send_fields(ModeWait, 4'd2, 32'd0, 32'd0);           // due one-shot poll
    send_fields(ModeArm, 4'd4, 32'd0, 32'd1);
    // all slots due at once: a full tick of expiries
    for (int i = 0; i < NumSlots; i++) send_fields(ModeArm, i[3:0], 32'd0, 32'd0);
    send_fields(ModeTick, 4'd0, 32'd0, 32'd0);

    write_step(10'd1000);
    send_fields(ModeTick, 4'd0, 32'd0, 32'd0);
    send_fields(ModeWait, 4'd0, 32'd0, 32'd0);           // one-shot poll, slot 0 was rearmed as one-shot
    send_fields(ModeWait, 4'd4, 32'd0, 32'd0);
    write_step(10'd0);
    send_fields(ModeTick, 4'd0, 32'd0, 32'd0);           // zero step still scans

    // random phases under the four idle patterns and several step sizes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; write_step(10'd1); end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; write_step(10'd12); end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 69;
          write_step(10'($urandom_range(2, 999)));
        end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; write_step(10'd1000); end
      endcase
      random_requests(55);
    end

    // arm a periodic slot with the largest delay, then keep ticking
    write_step(10'd1000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_fields(ModeArm, 4'd6, 32'hFFFF_FFFF, 32'd1);
    for (int i = 0; i < 8; i++) send_fields(ModeTick, 4'd0, 32'd0, 32'd0);
    send_fields(ModeWait, 4'd6, 32'd0, 32'd0);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("run covered %0d requests and %0d results over four idle patterns",
             requests_sent, sb.results_seen);
    $display("step sizes 0, 1, 12, 1000 and random; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/msopt_pkg.sv
hdl/msopt_div.sv
hdl/multi_slot_oneshot_periodic_timer.sv
sim/tb_multi_slot_oneshot_periodic_timer.sv
